>>> sv/cpd_pkg.sv
// Shared types and constants for the centered pixel doubler.
`timescale 1ns / 1ps
`default_nettype none

package cpd_pkg;

  localparam int DIM_W   = 13;
  localparam int COORD_W = 16;
  localparam int IDX_W   = 24;
  localparam int COLOR_W = 32;
  localparam int COL_W   = 8;
  localparam int ROW_W   = 9;

  localparam int BIG_W   = 512;
  localparam int BIG_H   = 480;
  localparam int SMALL_W = 256;
  localparam int SMALL_H = 240;

  localparam logic [0:0] CFG_FB_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FB_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COL_W-1:0]   src_col;
    logic [ROW_W-1:0]   src_row;
    logic [COLOR_W-1:0] pixel_color;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   fb_index;
    logic [COLOR_W-1:0] out_color;
    logic               last_write;
  } out_word_t;

  // Framebuffer geometry derived from the two size registers.
  typedef struct packed {
    logic                      scale2;
    logic [DIM_W-1:0]          w;
    logic [DIM_W-1:0]          h;
    logic signed [COORD_W-1:0] off_x;
    logic signed [COORD_W-1:0] off_y;
    logic [DIM_W-1:0]          lim_w;
    logic [DIM_W-1:0]          lim_h;
  } geom_t;

  // One classified pixel: base target and the set of writes that survive clipping.
  typedef struct packed {
    logic [DIM_W-1:0]   bx;
    logic [DIM_W-1:0]   by;
    logic [3:0]         mask;
    logic [COLOR_W-1:0] color;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/centered_pixel_doubler.sv
// Throughput: one framebuffer write per cycle while the output queue has room, set by
// the back-end write sequencer: a doubled pixel makes up to four writes, a 1:1 pixel
// at most one, a fully clipped pixel none.
// A two-entry command queue parts the front end from the back end.
// Reset: size registers return to 512x480 and all queues empty; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module centered_pixel_doubler #(
  parameter int SRC_COLS   = 256,
  parameter int SRC_ROWS   = 261,
  parameter int FB_DIM_MAX = 4096
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_push,
  output logic                           in_full,
  input  wire cpd_pkg::in_word_t         in_word,
  output logic                           out_empty,
  input  wire logic                      out_pop,
  output cpd_pkg::out_word_t             out_word,
  input  wire logic                      cfg_we,
  input  wire logic [0:0]                cfg_index,
  input  wire logic [cpd_pkg::DIM_W-1:0] cfg_wdata
);

  import cpd_pkg::*;

  localparam int CMD_DEPTH = 2;
  localparam int OUT_DEPTH = 4;
  localparam int CMD_BITS  = $bits(cmd_t);
  localparam int OUT_BITS  = $bits(out_word_t);

  geom_t                            geom;
  logic                             q_push, q_pop, q_full, q_empty;
  cmd_t                             q_cmd_in, q_cmd_out;
  logic [$clog2(CMD_DEPTH+1)-1:0]   q_count;
  logic                             of_push, of_full;
  out_word_t                        of_word;
  logic [$clog2(OUT_DEPTH+1)-1:0]   of_count;

  cpd_cfg #(
    .SRC_COLS   (SRC_COLS),
    .SRC_ROWS   (SRC_ROWS),
    .FB_DIM_MAX (FB_DIM_MAX)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .geom      (geom)
  );

  cpd_front u_front (
    .in_push (in_push),
    .in_word (in_word),
    .in_full (in_full),
    .geom    (geom),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd_in)
  );

  cpd_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_cmd_in),
    .pop   (q_pop),
    .rdata (q_cmd_out),
    .count (q_count),
    .full  (q_full),
    .empty (q_empty)
  );

  cpd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (q_cmd_out),
    .q_pop    (q_pop),
    .fb_w     (geom.w),
    .of_count (of_count),
    .of_push  (of_push),
    .of_word  (of_word)
  );

  // The back end never pushes a word without a free slot, so of_full is only informative.
  cpd_fifo #(
    .WIDTH (OUT_BITS),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (of_push && !of_full),
    .wdata (of_word),
    .pop   (out_pop && !out_empty),
    .rdata (out_word),
    .count (of_count),
    .full  (of_full),
    .empty (out_empty)
  );

  logic unused_q_count;
  assign unused_q_count = ^q_count;

endmodule

`default_nettype wire

>>> sv/cpd_fifo.sv
// Small register FIFO with occupancy count.
`timescale 1ns / 1ps
`default_nettype none

module cpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       pop,
  output logic      [WIDTH-1:0]           rdata,
  output logic      [$clog2(DEPTH+1)-1:0] count,
  output logic                            full,
  output logic                            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

endmodule

`default_nettype wire

>>> sv/cpd_cfg.sv
// Size registers and the geometry derived from them.
`timescale 1ns / 1ps
`default_nettype none

module cpd_cfg #(
  parameter int SRC_COLS   = 256,
  parameter int SRC_ROWS   = 261,
  parameter int FB_DIM_MAX = 4096
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [0:0]              cfg_index,
  input  wire logic [cpd_pkg::DIM_W-1:0] cfg_wdata,
  output cpd_pkg::geom_t               geom
);

  import cpd_pkg::*;

  localparam logic [DIM_W-1:0] LIM_COLS = DIM_W'(SRC_COLS);
  localparam logic [DIM_W-1:0] LIM_ROWS = DIM_W'(SRC_ROWS);
  localparam logic [DIM_W-1:0] DIM_SAT  = DIM_W'(FB_DIM_MAX);

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (32'(v) > FB_DIM_MAX) begin
      r = DIM_SAT;
    end
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] min_dim(input logic [DIM_W-1:0] a,
                                               input logic [DIM_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Halving of the margin truncates toward zero, so negative margins round up.
  function automatic logic signed [COORD_W-1:0] half_margin(
      input logic [DIM_W-1:0] v, input logic signed [COORD_W-1:0] area);
    logic signed [COORD_W-1:0] d;
    logic signed [COORD_W-1:0] d_adj;
    d     = $signed({{(COORD_W-DIM_W){1'b0}}, v}) - area;
    d_adj = d + $signed({{(COORD_W-1){1'b0}}, d[COORD_W-1]});
    return d_adj >>> 1;
  endfunction

  function automatic geom_t calc_geom(input logic [DIM_W-1:0] w,
                                      input logic [DIM_W-1:0] h);
    geom_t g;
    g.scale2 = (w >= DIM_W'(BIG_W)) && (h >= DIM_W'(BIG_H));
    g.w      = w;
    g.h      = h;
    if (g.scale2) begin
      g.off_x = half_margin(w, $signed(COORD_W'(BIG_W)));
      g.off_y = half_margin(h, $signed(COORD_W'(BIG_H)));
      g.lim_w = min_dim(w >> 1, LIM_COLS);
      g.lim_h = min_dim(h >> 1, LIM_ROWS);
    end else begin
      g.off_x = half_margin(w, $signed(COORD_W'(SMALL_W)));
      g.off_y = half_margin(h, $signed(COORD_W'(SMALL_H)));
      g.lim_w = min_dim(w, LIM_COLS);
      g.lim_h = min_dim(h, LIM_ROWS);
    end
    return g;
  endfunction

  geom_t            geom_r, geom_nxt;
  logic [DIM_W-1:0] w_nxt, h_nxt;

  always_comb begin
    w_nxt = geom_r.w;
    h_nxt = geom_r.h;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FB_WIDTH:  w_nxt = sat_dim(cfg_wdata);
        CFG_FB_HEIGHT: h_nxt = sat_dim(cfg_wdata);
        default: ;
      endcase
    end
    geom_nxt = calc_geom(w_nxt, h_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r <= calc_geom(DIM_W'(BIG_W), DIM_W'(BIG_H));
    end else begin
      geom_r <= geom_nxt;
    end
  end

  assign geom = geom_r;

endmodule

`default_nettype wire

>>> sv/cpd_front.sv
// Front end: accepts source pixels, places them and clips their writes.
`timescale 1ns / 1ps
`default_nettype none

module cpd_front (
  input  wire logic              in_push,
  input  wire cpd_pkg::in_word_t in_word,
  output logic                   in_full,
  input  wire cpd_pkg::geom_t    geom,
  input  wire logic              q_full,
  output logic                   q_push,
  output cpd_pkg::cmd_t          q_cmd
);

  import cpd_pkg::*;

  function automatic logic in_span(input logic signed [COORD_W-1:0] v,
                                   input logic [DIM_W-1:0] lim);
    return !v[COORD_W-1] && (v < $signed({{(COORD_W-DIM_W){1'b0}}, lim}));
  endfunction

  logic                      in_pic;
  logic [COORD_W-1:0]        col_pos, row_pos;
  logic signed [COORD_W-1:0] bx, by, bx1, by1;
  logic                      x0_ok, x1_ok, y0_ok, y1_ok;
  logic [3:0]                mask;

  always_comb begin
    in_pic = ({{(DIM_W-COL_W){1'b0}}, in_word.src_col} < geom.lim_w) &&
             ({{(DIM_W-ROW_W){1'b0}}, in_word.src_row} < geom.lim_h);
    if (geom.scale2) begin
      col_pos = {{(COORD_W-COL_W-1){1'b0}}, in_word.src_col, 1'b0};
      row_pos = {{(COORD_W-ROW_W-1){1'b0}}, in_word.src_row, 1'b0};
    end else begin
      col_pos = {{(COORD_W-COL_W){1'b0}}, in_word.src_col};
      row_pos = {{(COORD_W-ROW_W){1'b0}}, in_word.src_row};
    end
    bx  = $signed(col_pos) + geom.off_x;
    by  = $signed(row_pos) + geom.off_y;
    bx1 = bx + $signed(COORD_W'(1));
    by1 = by + $signed(COORD_W'(1));
    x0_ok = in_span(bx, geom.w);
    x1_ok = in_span(bx1, geom.w);
    y0_ok = in_span(by, geom.h);
    y1_ok = in_span(by1, geom.h);
    // Write order is (x,y), (x+1,y), (x+1,y+1), (x,y+1).
    if (!in_pic) begin
      mask = 4'b0000;
    end else if (geom.scale2) begin
      mask = {x0_ok & y1_ok, x1_ok & y1_ok, x1_ok & y0_ok, x0_ok & y0_ok};
    end else begin
      mask = {3'b000, x0_ok & y0_ok};
    end
  end

  assign in_full     = q_full;
  assign q_push      = in_push && !q_full && (mask != 4'b0000);
  assign q_cmd.bx    = bx[DIM_W-1:0];
  assign q_cmd.by    = by[DIM_W-1:0];
  assign q_cmd.mask  = mask;
  assign q_cmd.color = in_word.pixel_color;

endmodule

`default_nettype wire

>>> sv/cpd_back.sv
// Back end: walks the surviving writes of each pixel and forms framebuffer indexes.
`timescale 1ns / 1ps
`default_nettype none

module cpd_back #(
  parameter int OUT_DEPTH = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             q_empty,
  input  wire cpd_pkg::cmd_t                    q_cmd,
  output logic                                  q_pop,
  input  wire logic [cpd_pkg::DIM_W-1:0]        fb_w,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]   of_count,
  output logic                                  of_push,
  output cpd_pkg::out_word_t                    of_word
);

  import cpd_pkg::*;

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  logic               cur_valid_r, cur_valid_nxt;
  logic [3:0]         cur_mask_r, cur_mask_nxt;
  logic [DIM_W-1:0]   cur_bx_r, cur_by_r;
  logic [COLOR_W-1:0] cur_color_r;

  logic               s1_valid_r;
  logic [DIM_W-1:0]   s1_x_r, s1_y_r;
  logic [COLOR_W-1:0] s1_color_r;
  logic               s1_last_r;

  logic [3:0]         sel, rem_after;
  logic               issue, last, load, space_ok;
  logic [DIM_W-1:0]   wx, wy;
  logic [2*DIM_W-1:0] prod;
  logic [2*DIM_W:0]   idx_sum;

  // Words in the queue plus the one in flight must leave a free slot.
  assign space_ok = ({1'b0, of_count} + {{CNT_W{1'b0}}, s1_valid_r}) <
                    (CNT_W + 1)'(OUT_DEPTH);

  always_comb begin
    sel       = cur_mask_r & (~cur_mask_r + 4'd1);
    rem_after = cur_mask_r & ~sel;
    last      = (rem_after == 4'b0000);
    issue     = cur_valid_r && space_ok;
    wx        = cur_bx_r + {{(DIM_W-1){1'b0}}, sel[1] | sel[2]};
    wy        = cur_by_r + {{(DIM_W-1){1'b0}}, sel[2] | sel[3]};
    load      = !q_empty && (!cur_valid_r || (issue && last));

    cur_mask_nxt  = issue ? rem_after : cur_mask_r;
    cur_valid_nxt = cur_valid_r && !(issue && last);
    if (load) begin
      cur_mask_nxt  = q_cmd.mask;
      cur_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      s1_valid_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    cur_mask_r <= cur_mask_nxt;
    if (load) begin
      cur_bx_r    <= q_cmd.bx;
      cur_by_r    <= q_cmd.by;
      cur_color_r <= q_cmd.color;
    end
    if (issue) begin
      s1_x_r     <= wx;
      s1_y_r     <= wy;
      s1_color_r <= cur_color_r;
      s1_last_r  <= last;
    end
  end

  assign prod    = s1_y_r * fb_w;
  assign idx_sum = {1'b0, prod} + {{(DIM_W+1){1'b0}}, s1_x_r};

  assign q_pop              = load;
  assign of_push            = s1_valid_r;
  assign of_word.fb_index   = idx_sum[IDX_W-1:0];
  assign of_word.out_color  = s1_color_r;
  assign of_word.last_write = s1_last_r;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for centered_pixel_doubler: predicts and checks every framebuffer write.
`timescale 1ns / 1ps

module testbench;
  import cpd_pkg::*;

  localparam int PIC_COLS      = 256;
  localparam int PIC_ROWS      = 261;
  localparam int DIM_LIMIT     = 4096;
  localparam int SETTLE_CYCLES = 20;
  localparam int SHOWN_FAILS   = 10;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_push   = 1'b0;
  logic             in_full;
  in_word_t         in_word   = '0;
  logic             out_empty;
  logic             out_pop   = 1'b0;
  out_word_t        out_word;
  logic             cfg_we    = 1'b0;
  logic [0:0]       cfg_index = CFG_FB_WIDTH;
  logic [DIM_W-1:0] cfg_wdata = '0;

  // Framebuffer size as the block should see it, after saturation.
  longint    fb_w = BIG_W;
  longint    fb_h = BIG_H;
  out_word_t pending_writes[$];
  int        fail_count    = 0;
  int        in_idle_pct   = 37;
  int        out_stall_pct = 37;

  centered_pixel_doubler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void note_failure(string what);
    fail_count++;
    if (fail_count <= SHOWN_FAILS) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  function automatic void picture_limits(output bit big, output longint lim_w,
                                         output longint lim_h);
    big = (fb_w >= BIG_W) && (fb_h >= BIG_H);
    lim_w = big ? fb_w / 2 : fb_w;
    lim_h = big ? fb_h / 2 : fb_h;
    if (lim_w > PIC_COLS) lim_w = PIC_COLS;
    if (lim_h > PIC_ROWS) lim_h = PIC_ROWS;
  endfunction

  // Appends the writes one pixel causes and returns how many there are.
  function automatic int predict_writes(in_word_t px);
    bit        big;
    longint    lim_w, lim_h, off_x, off_y, col, row, x, y, idx;
    longint    tx[4], ty[4];
    int        n_cand, i;
    out_word_t kept[$];
    out_word_t wr;
    picture_limits(big, lim_w, lim_h);
    col = px.src_col;
    row = px.src_row;
    if (col >= lim_w || row >= lim_h) return 0;
    // Signed division truncates toward zero, so a negative odd margin rounds up.
    if (big) begin
      off_x = (fb_w - BIG_W) / 2;
      off_y = (fb_h - BIG_H) / 2;
      x = 2 * col + off_x;
      y = 2 * row + off_y;
      tx = '{x, x + 1, x + 1, x};
      ty = '{y, y, y + 1, y + 1};
      n_cand = 4;
    end else begin
      off_x = (fb_w - SMALL_W) / 2;
      off_y = (fb_h - SMALL_H) / 2;
      tx[0] = col + off_x;
      ty[0] = row + off_y;
      n_cand = 1;
    end
    for (i = 0; i < n_cand; i++) begin
      if (tx[i] >= 0 && tx[i] < fb_w && ty[i] >= 0 && ty[i] < fb_h) begin
        idx = ty[i] * fb_w + tx[i];
        wr.fb_index   = idx[IDX_W-1:0];
        wr.out_color  = px.pixel_color;
        wr.last_write = 1'b0;
        kept.push_back(wr);
      end
    end
    for (i = 0; i < kept.size(); i++) begin
      wr = kept[i];
      wr.last_write = (i == kept.size() - 1);
      pending_writes.push_back(wr);
    end
    return kept.size();
  endfunction

  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : write_checker
    out_word_t exp_w;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_writes.size() == 0) begin
        note_failure($sformatf("unexpected write: fb_index=%0d color=%h last=%b",
                               out_word.fb_index, out_word.out_color, out_word.last_write));
      end else begin
        exp_w = pending_writes.pop_front();
        if (out_word.fb_index !== exp_w.fb_index)
          note_failure($sformatf("fb_index: expected %0d, got %0d",
                                 exp_w.fb_index, out_word.fb_index));
        if (out_word.out_color !== exp_w.out_color)
          note_failure($sformatf("out_color at %0d: expected %h, got %h",
                                 exp_w.fb_index, exp_w.out_color, out_word.out_color));
        if (out_word.last_write !== exp_w.last_write)
          note_failure($sformatf("last_write at %0d: expected %b, got %b",
                                 exp_w.fb_index, exp_w.last_write, out_word.last_write));
      end
    end
  end

  // Called and returns at a falling edge; push stays high when the next word follows at once.
  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input logic [COLOR_W-1:0] color);
    in_word_t px;
    px.src_col     = col;
    px.src_row     = row;
    px.pixel_color = color;
    while ($urandom_range(99) < in_idle_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_word <= px;
    @(posedge clk);
    while (in_full) @(posedge clk);
    void'(predict_writes(px));
    @(negedge clk);
  endtask

  task automatic wait_for_writes;
    in_push <= 1'b0;
    do @(negedge clk); while (pending_writes.size() != 0);
  endtask

  task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    // A fully clipped pixel leaves no write behind, so give the pipeline time to empty.
    wait_for_writes();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_FB_WIDTH;
    cfg_wdata <= w;
    @(negedge clk);
    cfg_index <= CFG_FB_HEIGHT;
    cfg_wdata <= h;
    @(negedge clk);
    cfg_we <= 1'b0;
    fb_w = (w > DIM_LIMIT) ? DIM_LIMIT : w;
    fb_h = (h > DIM_LIMIT) ? DIM_LIMIT : h;
  endtask

  task automatic test_reset_geometry;
    send_pixel(8'd0, 9'd0, 32'h0000_0000);
    send_pixel(8'd255, 9'd0, 32'hFFFF_FFFF);
    send_pixel(8'd0, 9'd239, 32'hA5A5_A5A5);
    send_pixel(8'd255, 9'd239, 32'h5A5A_5A5A);
    // Rows past the doubled picture height emit nothing.
    send_pixel(8'd17, 9'd240, 32'h1234_5678);
    send_pixel(8'd3, 9'd511, 32'h8765_4321);
  endtask

  task automatic test_register_saturation;
    // Both values exceed the maximum and must saturate to 4096.
    set_geometry(13'd8191, 13'd4097);
    send_pixel(8'd255, 9'd260, 32'hDEAD_BEEF);
    send_pixel(8'd0, 9'd0, 32'h0F0F_0F0F);
    set_geometry(13'd4096, 13'd4096);
    send_pixel(8'd128, 9'd261, 32'hCAFE_F00D);
    // Odd sizes just above the doubling threshold keep a zero offset.
    set_geometry(13'd513, 13'd481);
    send_pixel(8'd255, 9'd239, 32'hF0F0_F0F0);
  endtask

  task automatic test_edge_clipping;
    // The bottom of the doubled picture hangs past the framebuffer.
    set_geometry(13'd512, 13'd501);
    send_pixel(8'd10, 9'd244, 32'h1111_1111);
    send_pixel(8'd10, 9'd245, 32'h2222_2222);
    send_pixel(8'd10, 9'd249, 32'h3333_3333);
    set_geometry(13'd511, 13'd480);
    send_pixel(8'd255, 9'd239, 32'h4444_4444);
    send_pixel(8'd0, 9'd240, 32'h5555_5555);
    // Narrow framebuffer: the 1:1 picture starts left of column zero.
    set_geometry(13'd100, 13'd300);
    send_pixel(8'd77, 9'd0, 32'h6666_6666);
    send_pixel(8'd78, 9'd0, 32'h7777_7777);
    send_pixel(8'd99, 9'd260, 32'h8888_8888);
    send_pixel(8'd100, 9'd0, 32'h9999_9999);
    set_geometry(13'd1, 13'd1);
    send_pixel(8'd0, 9'd0, 32'hAAAA_AAAA);
    set_geometry(13'd0, 13'd0);
    send_pixel(8'd0, 9'd0, 32'hBBBB_BBBB);
  endtask

  // Sends count random pixels, pausing once halfway until every write has come.
  task automatic run_random_pixels(input int count);
    bit     big;
    longint lim_w, lim_h;
    int     sent;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    picture_limits(big, lim_w, lim_h);
    for (sent = 0; sent < count; sent++) begin
      if (lim_w > 0 && lim_h > 0 && $urandom_range(99) < 85) begin
        col = COL_W'($urandom_range(int'(lim_w - 1)));
        row = ROW_W'($urandom_range(int'(lim_h - 1)));
      end else begin
        col = COL_W'($urandom_range(255));
        row = ROW_W'($urandom_range(511));
      end
      send_pixel(col, row, $urandom);
      if (sent == count / 2) begin
        wait_for_writes();
      end
    end
  endtask

  task automatic test_unstalled_stream;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    set_geometry(13'd512, 13'd480);
    run_random_pixels(60);
    in_idle_pct   = 37;
    out_stall_pct = 37;
  endtask

  task automatic test_random_geometry;
    logic [DIM_W-1:0] w, h;
    int phase;
    for (phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3))
        0: begin
          w = DIM_W'($urandom_range(4096, 512));
          h = DIM_W'($urandom_range(4096, 480));
        end
        1: begin
          w = DIM_W'($urandom_range(511, 90));
          h = DIM_W'($urandom_range(479, 90));
        end
        2: begin
          w = DIM_W'($urandom_range(8191, 4097));
          h = DIM_W'($urandom_range(4096, 480));
        end
        default: begin
          w = DIM_W'($urandom_range(1024, 512));
          h = DIM_W'($urandom_range(540, 481));
        end
      endcase
      set_geometry(w, h);
      run_random_pixels(48);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_geometry();
    test_register_saturation();
    test_edge_clipping();
    test_unstalled_stream();
    test_random_geometry();
    wait_for_writes();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_writes.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
sv/cpd_pkg.sv
sv/cpd_fifo.sv
sv/cpd_cfg.sv
sv/cpd_front.sv
sv/cpd_back.sv
sv/centered_pixel_doubler.sv
verif/testbench.sv
